[rtl/assert_macros.svh]
// Assertion macros for the checker module of the page run allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define PRA_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define PRA_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/pra_pkg.sv]
// Shared types and constants of the page run allocator.
package pra_pkg;

  // Fixed region size and counts of ports and owners
  localparam int TOTAL_PAGES = 256;
  localparam int PORT_COUNT  = 4;
  localparam int NUM_OWNERS  = 16;

  // Configuration register file: a start and a size register per port
  localparam int REG_COUNT  = 2 * PORT_COUNT;
  localparam int CFG_IDX_W  = 4;
  localparam logic REG_KIND_START = 1'b0;
  localparam logic REG_KIND_PAGES = 1'b1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_ROOM = 1'b1;

  // Request commands
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } pra_cmd_t;

  // Work handed to the back end
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_DONE    = 2'd3
  } pra_op_t;

  typedef struct packed {
    pra_op_t    op;
    logic [3:0] owner;
    logic [8:0] count;
    logic [7:0] lo;
    logic [8:0] hi;
    logic       status;
    logic [7:0] page;
  } pra_desc_t;

endpackage

[rtl/pra_front.sv]
// Front end: window registers, request classification and range setup.
module pra_front import pra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [3:0]           owner,
  input  logic [1:0]           port,
  input  logic [8:0]           page_count,
  input  logic [7:0]           first_page,
  input  logic                 q_room,
  input  logic                 init_done,
  output logic                 push,
  output pra_desc_t            push_desc
);

  localparam int EW = ($clog2(TOTAL_PAGES) + 1 > 10) ? $clog2(TOTAL_PAGES) + 1 : 10;

  logic [7:0] win_start [PORT_COUNT];
  logic [8:0] win_pages [PORT_COUNT];

  logic       cfg_hit;
  logic [1:0] cfg_sel;
  logic [9:0] win_sum;
  logic [8:0] win_end;
  logic       win_bad;
  logic [9:0] fr_sum;
  logic [8:0] fr_end;
  logic       port_ok;
  logic       owner_ok;

  // Register writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_index < CFG_IDX_W'(REG_COUNT);
  assign cfg_sel   = cfg_index[2:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PORT_COUNT; i++) begin
        win_start[i] <= '0;
        win_pages[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready && cfg_hit) begin
      if (cfg_index[0] == REG_KIND_START) begin
        win_start[cfg_sel] <= cfg_data[7:0];
      end else begin
        win_pages[cfg_sel] <= cfg_data;
      end
    end
  end

  // Window end and free range end, both clipped to the region
  always_comb begin
    port_ok  = 32'(port) < PORT_COUNT;
    owner_ok = 32'(owner) < NUM_OWNERS;
    win_sum  = {2'b00, win_start[port]} + {1'b0, win_pages[port]};
    win_end  = (EW'(win_sum) > EW'(TOTAL_PAGES)) ? 9'(TOTAL_PAGES) : win_sum[8:0];
    win_bad  = {1'b0, win_start[port]} > win_end;
    fr_sum   = {2'b00, first_page} + {1'b0, page_count};
    fr_end   = (EW'(fr_sum) > EW'(TOTAL_PAGES)) ? 9'(TOTAL_PAGES) : fr_sum[8:0];
  end

  // Classify: immediate results go straight through as done entries
  always_comb begin
    push_desc.op     = OP_DONE;
    push_desc.owner  = owner;
    push_desc.count  = page_count;
    push_desc.lo     = first_page;
    push_desc.hi     = fr_end;
    push_desc.status = STATUS_OK;
    push_desc.page   = '0;
    case (cmd)
      CMD_ALLOC: begin
        push_desc.lo = win_start[port];
        push_desc.hi = win_end;
        if (!port_ok || !owner_ok || win_bad) begin
          push_desc.status = STATUS_NO_ROOM;
        end else if (page_count == 9'd0) begin
          push_desc.page = win_start[port];
        end else begin
          push_desc.op = OP_ALLOC;
        end
      end
      CMD_FREE: begin
        if (owner_ok && ({1'b0, first_page} < fr_end)) begin
          push_desc.op = OP_FREE;
        end
      end
      CMD_RELEASE: begin
        if (owner_ok) begin
          push_desc.op = OP_RELEASE;
        end
      end
      default: begin
        push_desc.op = OP_DONE;
      end
    endcase
  end

  assign in_ready = q_room && init_done;
  assign push     = in_valid && in_ready;

endmodule

[rtl/pra_queue.sv]
// Short request queue between the front end and the page table engine.
module pra_queue import pra_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  pra_desc_t push_desc,
  output logic      room,
  input  logic      pop,
  output logic      valid,
  output pra_desc_t desc
);

  pra_desc_t           entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   cnt;

  assign room  = cnt != QCNT_W'(QUEUE_DEPTH);
  assign valid = cnt != '0;
  assign desc  = entries[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[rtl/pra_back.sv]
// Back end: page table memory, run scan, fill, range sweep and result register.
module pra_back import pra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  pra_desc_t  q_desc,
  output logic       q_pop,
  output logic       init_done,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       status,
  output logic [7:0] alloc_page
);

  localparam int AW = $clog2(TOTAL_PAGES);
  localparam int CW = (AW + 1 > 9) ? AW + 1 : 9;

  typedef struct packed {
    logic       used;
    logic [3:0] owner;
  } pra_entry_t;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_FILL  = 6'b001000,
    ST_SWEEP = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  pra_entry_t mem [TOTAL_PAGES];
  pra_entry_t rd_entry;
  logic          we;
  logic [AW-1:0] waddr;
  pra_entry_t    wdata;

  state_t        state;
  logic [CW-1:0] p;
  logic [CW-1:0] q;
  logic [CW-1:0] hi;
  logic          pend;
  logic [8:0]    run;
  logic [8:0]    count;
  logic [3:0]    own;
  logic          res_status;
  logic [7:0]    res_page;

  logic          issue;
  logic          found;
  logic          match;
  logic [CW-1:0] first;
  logic          res_room;

  // Page table: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_entry <= mem[p[AW-1:0]];
  end

  always_comb begin
    issue    = p < hi;
    found    = pend && !rd_entry.used && ({1'b0, run} + 10'd1 == {1'b0, count});
    match    = pend && rd_entry.used && (rd_entry.owner == own);
    first    = q + CW'(1) - CW'(count);
    res_room = !out_valid || out_ready;
  end

  // Write port source per state
  always_comb begin
    we    = 1'b0;
    waddr = p[AW-1:0];
    wdata = '0;
    case (state)
      ST_INIT: begin
        we = 1'b1;
      end
      ST_FILL: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, owner: own};
      end
      ST_SWEEP: begin
        we    = match;
        waddr = q[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign init_done = state != ST_INIT;

  // Output register: loaded from the done state, emptied when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && res_room) begin
      out_valid  <= 1'b1;
      status     <= res_status;
      alloc_page <= res_page;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      p     <= '0;
      pend  <= 1'b0;
    end else begin
      case (state)
        // Clearing pass over the whole table
        ST_INIT: begin
          p <= p + 1'b1;
          if (p == CW'(TOTAL_PAGES - 1)) begin
            state <= ST_IDLE;
          end
        end
        // Take the next request off the queue
        ST_IDLE: begin
          if (q_valid) begin
            pend       <= 1'b0;
            run        <= '0;
            own        <= q_desc.owner;
            count      <= q_desc.count;
            res_status <= q_desc.status;
            res_page   <= q_desc.page;
            p          <= CW'(q_desc.lo);
            hi         <= CW'(q_desc.hi);
            case (q_desc.op)
              OP_ALLOC: state <= ST_SCAN;
              OP_FREE:  state <= ST_SWEEP;
              OP_RELEASE: begin
                p     <= '0;
                hi    <= CW'(TOTAL_PAGES);
                state <= ST_SWEEP;
              end
              default: state <= ST_DONE;
            endcase
          end
        end
        // First-fit scan, one page per cycle
        ST_SCAN: begin
          if (found) begin
            p          <= first;
            hi         <= q;
            res_page   <= first[7:0];
            res_status <= STATUS_OK;
            pend       <= 1'b0;
            state      <= ST_FILL;
          end else if (!pend && !issue) begin
            res_status <= STATUS_NO_ROOM;
            res_page   <= '0;
            state      <= ST_DONE;
          end else begin
            pend <= issue;
            q    <= p;
            if (issue) begin
              p <= p + 1'b1;
            end
            if (pend) begin
              run <= rd_entry.used ? '0 : run + 1'b1;
            end
          end
        end
        // Mark the found run as owned
        ST_FILL: begin
          p <= p + 1'b1;
          if (p == hi) begin
            state <= ST_DONE;
          end
        end
        // Clear pages of the owner across a range
        ST_SWEEP: begin
          if (!pend && !issue) begin
            state <= ST_DONE;
          end else begin
            pend <= issue;
            q    <= p;
            if (issue) begin
              p <= p + 1'b1;
            end
          end
        end
        // Wait until the output register can take the result
        ST_DONE: begin
          if (res_room) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/page_run_allocator_unit.sv]
// Page run allocator top level: front end, request queue and page table engine.
// Requests enter a two-entry queue and complete one at a time against a
// page table with one write and one registered read port, read one page per
// cycle. The engine takes a request off the queue, then: an allocate scans the
// window from its start to the end of the first free run that fits and marks
// that run as owned, a failed allocate scans the whole window, a free sweeps
// the pages in its range, a release sweeps the whole table, and requests
// answered without touching the table (zero length, bad window or owner,
// empty free range, unknown command) go straight to the result. After reset
// the table is cleared in full, during which in_ready stays low; register
// writes are taken at any time. Results come in request order through an
// output register.
module page_run_allocator_unit import pra_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [8:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           cmd,
  input  logic [3:0]           owner,
  input  logic [1:0]           port,
  input  logic [8:0]           page_count,
  input  logic [7:0]           first_page,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 status,
  output logic [7:0]           alloc_page
);

  logic      q_room;
  logic      push;
  pra_desc_t push_desc;
  logic      q_valid;
  pra_desc_t q_desc;
  logic      q_pop;
  logic      init_done;

  pra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .owner     (owner),
    .port      (port),
    .page_count(page_count),
    .first_page(first_page),
    .q_room    (q_room),
    .init_done (init_done),
    .push      (push),
    .push_desc (push_desc)
  );

  pra_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .room     (q_room),
    .pop      (q_pop),
    .valid    (q_valid),
    .desc     (q_desc)
  );

  pra_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_desc    (q_desc),
    .q_pop     (q_pop),
    .init_done (init_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .alloc_page(alloc_page)
  );

endmodule

[rtl/pra_checker.sv]
// Port-level checker of the page run allocator and its bind.
`include "assert_macros.svh"

module pra_checker import pra_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       status,
  input logic [7:0] alloc_page
);

  logic [2:0] outstanding;

  // Requests accepted but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  `PRA_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !in_ready && !out_valid, "busy after reset")
  `PRA_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(alloc_page), "result changed while stalled")
  `PRA_ASSERT(a_no_room_page, clk, rst, out_valid && status == STATUS_NO_ROOM |-> alloc_page == 8'd0, "page set on failed allocate")
  `PRA_ASSERT(a_no_extra_result, clk, rst, out_valid |-> outstanding != 3'd0, "result without request")

endmodule

bind page_run_allocator_unit pra_checker u_checker (.*);

[tb/page_run_allocator_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the page run allocator: directed table, then random phases.
module page_run_allocator_unit_tb;
  import pra_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES = 600;
  localparam int RANDOM_ITEMS = 100;
  localparam int MAX_LIVE_RUNS = 64;

  // Window register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P0_START = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P0_PAGES = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P1_START = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_P1_PAGES = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_P2_START = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_P2_PAGES = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_P3_START = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_P3_PAGES = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_END = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX = 4'd15;

  typedef enum int {PACE_FULL, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

  typedef struct packed {
    pra_cmd_t   cmd;
    logic [3:0] owner;
    logic [1:0] port;
    logic [8:0] count;
    logic [7:0] first;
  } request_t;

  typedef struct packed {
    logic       status;
    logic [7:0] page;
  } reply_t;

  typedef struct packed {
    logic [3:0] owner;
    logic [7:0] first;
    logic [8:0] count;
  } run_t;

  // One row of the directed table: a register write or a request
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [8:0]           reg_data;
    request_t             req;
    bit                   known;
    reply_t               want;
  } step_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [8:0]           cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           cmd;
  logic [3:0]           owner;
  logic [1:0]           port;
  logic [8:0]           page_count;
  logic [7:0]           first_page;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 status;
  logic [7:0]           alloc_page;

  // Shadow page table and window registers
  bit         page_taken [TOTAL_PAGES];
  logic [3:0] page_holder [TOTAL_PAGES];
  logic [7:0] win_first [PORT_COUNT];
  logic [8:0] win_size [PORT_COUNT];

  reply_t pending_replies [$];
  run_t   live_runs [$];
  step_t  directed_steps [$];
  pace_t  pace = PACE_FULL;
  int     mismatches = 0;
  int     cycle_count;

  page_run_allocator_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .owner(owner), .port(port), .page_count(page_count), .first_page(first_page),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .alloc_page(alloc_page)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expected reply for one request; updates the shadow page table
  function automatic reply_t apply_page_request(request_t r);
    reply_t rep;
    int lo, hi, n, run, p, q;
    bit found;
    rep.status = STATUS_OK;
    rep.page = '0;
    n = int'(r.count);
    case (r.cmd)
      CMD_ALLOC: begin
        lo = int'(win_first[r.port]);
        hi = lo + int'(win_size[r.port]);
        if (hi > TOTAL_PAGES) hi = TOTAL_PAGES;
        if (n == 0) begin
          // zero length: window start, nothing marked
          rep.page = win_first[r.port];
        end else begin
          run = 0;
          found = 1'b0;
          for (p = lo; p < hi && !found; p++) begin
            run = page_taken[p] ? 0 : run + 1;
            if (run == n) begin
              found = 1'b1;
              for (q = p + 1 - n; q <= p; q++) begin
                page_taken[q] = 1'b1;
                page_holder[q] = r.owner;
              end
              rep.page = 8'(p + 1 - n);
            end
          end
          if (!found) rep.status = STATUS_NO_ROOM;
        end
      end
      CMD_FREE, CMD_RELEASE: begin
        // free covers a range, release the whole region; only own pages clear
        lo = (r.cmd == CMD_FREE) ? int'(r.first) : 0;
        hi = (r.cmd == CMD_FREE) ? int'(r.first) + n : TOTAL_PAGES;
        if (hi > TOTAL_PAGES) hi = TOTAL_PAGES;
        for (p = lo; p < hi; p++) begin
          if (page_taken[p] && page_holder[p] == r.owner) begin
            page_taken[p] = 1'b0;
            page_holder[p] = '0;
          end
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
    step_t s;
    s.is_reg = 1'b1;
    s.reg_idx = idx;
    s.reg_data = data;
    s.req = '0;
    s.known = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t req_row(pra_cmd_t c, int o, int pt, int n, int f);
    step_t s;
    s.is_reg = 1'b0;
    s.reg_idx = '0;
    s.reg_data = '0;
    s.req.cmd = c;
    s.req.owner = 4'(o);
    s.req.port = 2'(pt);
    s.req.count = 9'(n);
    s.req.first = 8'(f);
    s.known = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t req_known(pra_cmd_t c, int o, int pt, int n, int f,
                                      logic st, int pg);
    step_t s;
    s = req_row(c, o, pt, n, f);
    s.known = 1'b1;
    s.want.status = st;
    s.want.page = 8'(pg);
    return s;
  endfunction

  // Mostly well-formed traffic: small allocations and frees of runs held
  function automatic request_t next_random_request();
    request_t r;
    run_t pick;
    int roll, k;
    r.cmd = CMD_ALLOC;
    r.owner = 4'($urandom_range(15));
    r.port = 2'($urandom_range(3));
    r.first = 8'($urandom_range(255));
    k = $urandom_range(99);
    if (k < 5) r.count = '0;
    else if (k < 75) r.count = 9'($urandom_range(8, 1));
    else if (k < 95) r.count = 9'($urandom_range(64, 9));
    else r.count = 9'($urandom_range(256, 65));
    roll = $urandom_range(99);
    if (roll < 50) begin
      r.cmd = CMD_ALLOC;
    end else if (roll < 80) begin
      r.cmd = CMD_FREE;
      if (live_runs.size() != 0 && $urandom_range(9) < 8) begin
        k = $urandom_range(live_runs.size() - 1);
        pick = live_runs[k];
        live_runs.delete(k);
        r.owner = pick.owner;
        r.first = pick.first;
        r.count = pick.count;
        if ($urandom_range(4) == 0) begin
          // partial or shifted range
          r.first = pick.first + 8'($urandom_range(3));
          r.count = 9'($urandom_range(int'(pick.count)));
        end else if ($urandom_range(9) == 0) begin
          // likely someone else's pages
          r.owner = 4'($urandom_range(15));
        end
      end else begin
        r.count = 9'($urandom_range(511));
      end
    end else if (roll < 90) begin
      r.cmd = CMD_RELEASE;
    end else if (roll < 95) begin
      r.cmd = CMD_NONE;
    end else begin
      r.count = 9'($urandom_range(511));
    end
    return r;
  endfunction

  task automatic write_window_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx < REG_COUNT) begin
      if (idx[0] == REG_KIND_START) win_first[idx >> 1] = data[7:0];
      else win_size[idx >> 1] = data;
    end
  endtask

  // Send one request; a known reply overrides the predicted one
  task automatic issue_request(request_t r, bit known, reply_t want);
    reply_t rep;
    int gap, idle_pct;
    gap = 0;
    idle_pct = (pace == PACE_SENDER) ? 58 : (pace == PACE_BOTH) ? 34 : 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= r.cmd;
    owner <= r.owner;
    port <= r.port;
    page_count <= r.count;
    first_page <= r.first;
    do @(posedge clk); while (!in_ready);
    rep = apply_page_request(r);
    pending_replies.push_back(known ? want : rep);
    if (r.cmd == CMD_ALLOC && rep.status == STATUS_OK && r.count != 0) begin
      live_runs.push_back('{r.owner, rep.page, r.count});
      if (live_runs.size() > MAX_LIVE_RUNS) void'(live_runs.pop_front());
    end
  endtask

  task automatic wait_for_replies();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // New windows while idle, then a run of random requests
  task automatic run_phase(pace_t mode, int items, bit hold_midway);
    int pt, k;
    logic [8:0] pages;
    pace = mode;
    wait_for_replies();
    for (pt = 0; pt < PORT_COUNT; pt++) begin
      k = $urandom_range(9);
      write_window_reg(4'(2 * pt + int'(REG_KIND_START)),
                       (k == 0) ? 9'd0 : (k == 1) ? 9'd255 : 9'($urandom_range(511)));
      k = $urandom_range(19);
      if (k == 0) pages = 9'd0;
      else if (k == 1) pages = 9'd256;
      else if (k == 2) pages = 9'($urandom_range(511, 257));
      else pages = 9'($urandom_range(256, 16));
      write_window_reg(4'(2 * pt + int'(REG_KIND_PAGES)), pages);
    end
    write_window_reg(4'($urandom_range(15, 8)), 9'($urandom_range(511)));
    cfg_valid <= 1'b0;
    for (k = 0; k < items; k++) begin
      if (hold_midway && k == items / 2) wait_for_replies();
      issue_request(next_random_request(), 1'b0, '0);
    end
  endtask

  // Reply check and receiver stalls
  always @(posedge clk) begin : reply_check
    reply_t want;
    int stall_pct;
    if (!rst && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: status %0d, alloc_page %0d", status, alloc_page);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (alloc_page !== want.page) begin
          $error("alloc_page: expected %0d, got %0d", want.page, alloc_page);
          mismatches++;
        end
      end
    end
    stall_pct = (pace == PACE_RECEIVER) ? 58 : (pace == PACE_BOTH) ? 34 : 0;
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    cmd = CMD_ALLOC;
    owner = '0;
    port = '0;
    page_count = '0;
    first_page = '0;
    foreach (page_taken[i]) begin
      page_taken[i] = 1'b0;
      page_holder[i] = '0;
    end
    foreach (win_first[i]) begin
      win_first[i] = '0;
      win_size[i] = '0;
    end

    directed_steps = '{
      // empty windows after reset
      req_known(CMD_ALLOC, 1, 0, 0, 0, STATUS_OK, 0),
      req_known(CMD_ALLOC, 1, 0, 1, 0, STATUS_NO_ROOM, 0),
      // full region, one-page window at the top, empty window, window ending at the region end
      reg_row(REG_P0_START, 9'd0),
      reg_row(REG_P0_PAGES, 9'd256),
      reg_row(REG_P1_START, 9'd255),
      reg_row(REG_P1_PAGES, 9'd256),
      reg_row(REG_P2_START, 9'd200),
      reg_row(REG_P2_PAGES, 9'd0),
      reg_row(REG_P3_START, 9'h1F0),
      reg_row(REG_P3_PAGES, 9'd16),
      reg_row(REG_PAST_END, 9'd100),
      reg_row(REG_LAST_INDEX, 9'd0),
      req_known(CMD_ALLOC, 2, 0, 256, 255, STATUS_OK, 0),
      req_known(CMD_ALLOC, 3, 1, 1, 0, STATUS_NO_ROOM, 0),
      // foreign pages stay, range past the region is cut
      req_known(CMD_FREE, 3, 2, 256, 0, STATUS_OK, 0),
      req_known(CMD_FREE, 2, 3, 511, 250, STATUS_OK, 0),
      req_known(CMD_ALLOC, 3, 1, 1, 0, STATUS_OK, 255),
      req_known(CMD_ALLOC, 4, 1, 2, 0, STATUS_NO_ROOM, 0),
      req_known(CMD_ALLOC, 5, 2, 0, 0, STATUS_OK, 200),
      req_row(CMD_ALLOC, 15, 3, 5, 0),
      req_known(CMD_RELEASE, 2, 0, 0, 0, STATUS_OK, 0),
      req_known(CMD_ALLOC, 0, 0, 511, 0, STATUS_NO_ROOM, 0),
      req_row(CMD_ALLOC, 7, 0, 3, 0),
      req_known(CMD_NONE, 7, 3, 511, 255, STATUS_OK, 0),
      req_known(CMD_FREE, 7, 0, 1, 1, STATUS_OK, 0),
      // first fit around the hole
      req_row(CMD_ALLOC, 8, 0, 2, 0),
      req_row(CMD_ALLOC, 9, 0, 1, 0),
      req_known(CMD_FREE, 15, 1, 0, 255, STATUS_OK, 0),
      req_known(CMD_RELEASE, 15, 0, 0, 0, STATUS_OK, 0),
      req_known(CMD_RELEASE, 3, 0, 0, 0, STATUS_OK, 0),
      req_row(CMD_ALLOC, 15, 3, 16, 0),
      req_known(CMD_ALLOC, 6, 3, 1, 0, STATUS_NO_ROOM, 0),
      req_row(CMD_FREE, 15, 0, 8, 244),
      req_row(CMD_ALLOC, 10, 3, 8, 0)
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_reg) begin
        if (pending_replies.size() != 0) wait_for_replies();
        write_window_reg(directed_steps[i].reg_idx, directed_steps[i].reg_data);
      end else begin
        cfg_valid <= 1'b0;
        issue_request(directed_steps[i].req, directed_steps[i].known, directed_steps[i].want);
      end
    end

    run_phase(PACE_FULL, RANDOM_ITEMS, 1'b1);
    run_phase(PACE_SENDER, RANDOM_ITEMS, 1'b0);
    run_phase(PACE_RECEIVER, RANDOM_ITEMS, 1'b0);
    run_phase(PACE_BOTH, RANDOM_ITEMS, 1'b0);

    wait_for_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
